// ----- rtl/mexp_pkg.sv -----
// Shared constants for the modular exponentiation block.
package mexp_pkg;

	localparam longint unsigned RESET_MODULUS = 64'd1000000007;

	localparam logic KIND_POWER   = 1'b0;
	localparam logic KIND_INVERSE = 1'b1;

	localparam int unsigned MIN_PRIME_GAP = 2;

endpackage

// ----- rtl/mexp_mulmod.sv -----
// Bit-serial interleaved modular multiplier: per multiplier bit, MSB first, a doubling step then an add step.
module mexp_mulmod #(
	parameter int MOD_BITS = 31
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                go,
	input  logic [MOD_BITS-1:0] a,
	input  logic [MOD_BITS-1:0] b,
	input  logic [MOD_BITS-1:0] m,
	output logic [MOD_BITS-1:0] product,
	output logic                done
);

	localparam int CW = (MOD_BITS > 1) ? $clog2(MOD_BITS) : 1;

	logic                running_q;
	logic                phase_q;
	logic                done_q;
	logic [CW-1:0]       cnt_q;
	logic [MOD_BITS-1:0] r_q;
	logic [MOD_BITS-1:0] a_q;
	logic [MOD_BITS-1:0] b_q;

	logic [MOD_BITS:0]   dbl;
	logic [MOD_BITS:0]   sum;
	logic [MOD_BITS:0]   mx;
	logic [MOD_BITS:0]   pick;
	logic [MOD_BITS:0]   red;

	always_comb begin
		mx   = {1'b0, m};
		dbl  = {r_q, 1'b0};
		sum  = {1'b0, r_q} + (b_q[MOD_BITS-1] ? {1'b0, a_q} : '0);
		pick = phase_q ? sum : dbl;
		red  = (pick >= mx) ? (pick - mx) : pick;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			phase_q   <= 1'b0;
			done_q    <= 1'b0;
			cnt_q     <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				running_q <= 1'b1;
				phase_q   <= 1'b0;
				cnt_q     <= CW'(MOD_BITS - 1);
			end else if (running_q) begin
				phase_q <= ~phase_q;
				if (phase_q) begin
					if (cnt_q == '0) begin
						running_q <= 1'b0;
						done_q    <= 1'b1;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			r_q <= '0;
			a_q <= a;
			b_q <= b;
		end else if (running_q) begin
			r_q <= red[MOD_BITS-1:0];
			if (phase_q) begin
				b_q <= {b_q[MOD_BITS-2:0], 1'b0};
			end
		end
	end

	assign product = r_q;
	assign done    = done_q;

endmodule

// ----- rtl/modular_exponentiation.sv -----
// Top level: right-to-left square-and-multiply modular exponentiation.
//
// Usage:
//   Write the modulus on the cfg channel (cfg_valid/cfg_ready, one beat, data
//   on cfg_data) while the block is idle and start is low; reset loads
//   1000000007.
//   Issue a command by raising start with kind, base_value and exponent; it
//   is taken at a clock edge where busy is low. kind 0 raises base_value to
//   exponent, kind 1 uses exponent = modulus - 2 (inverse for a prime
//   modulus). result is shown for one cycle under result_valid, after which
//   busy drops and the next command may be taken.
// Timing:
//   One shared bit-serial multiplier does all the work, one modular product
//   at a time. A command costs one base reduction, then per exponent bit one
//   squaring plus one multiply where the bit is set; the strobe follows the
//   last squaring, and busy drops after the strobe. A zero modulus strobes 0
//   in the next cycle. Reset drops any command in flight without a result.
//   The receiver cannot stall: result_valid is a one-cycle strobe.
module modular_exponentiation #(
	parameter int MOD_BITS = 31,
	parameter int EXP_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                kind,
	input  logic [MOD_BITS-1:0] base_value,
	input  logic [EXP_BITS-1:0] exponent,
	output logic                result_valid,
	output logic [MOD_BITS-1:0] result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [MOD_BITS-1:0] cfg_data
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RED  = 3'd1;
	localparam logic [2:0] ST_ACC  = 3'd2;
	localparam logic [2:0] ST_SQ   = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	localparam int EW = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;

	logic [2:0]          state_q;
	logic [MOD_BITS-1:0] mod_q;
	logic [MOD_BITS-1:0] acc_q;
	logic [MOD_BITS-1:0] sq_q;
	logic [MOD_BITS-1:0] base_q;
	logic [EXP_BITS-1:0] exp_q;
	logic [EW-1:0]       cnt_q;
	logic                go_q;

	logic                accept;
	logic [MOD_BITS-1:0] one_mod;
	logic [MOD_BITS-1:0] mod_less2;
	logic [EXP_BITS-1:0] inv_exp;
	logic [EXP_BITS-1:0] new_exp;
	logic [MOD_BITS-1:0] mm_a;
	logic [MOD_BITS-1:0] mm_b;
	logic [MOD_BITS-1:0] mm_p;
	logic                mm_done;

	assign accept    = start && !busy;
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = !busy && !start;

	always_comb begin
		one_mod   = (mod_q == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);
		mod_less2 = (mod_q >= MOD_BITS'(mexp_pkg::MIN_PRIME_GAP))
			? (mod_q - MOD_BITS'(mexp_pkg::MIN_PRIME_GAP)) : '0;
		inv_exp   = EXP_BITS'({{EXP_BITS{1'b0}}, mod_less2});
		new_exp   = (kind == mexp_pkg::KIND_INVERSE) ? inv_exp : exponent;
	end

	always_comb begin
		unique case (state_q)
			ST_RED: begin
				mm_a = one_mod;
				mm_b = base_q;
			end
			ST_ACC: begin
				mm_a = sq_q;
				mm_b = acc_q;
			end
			default: begin
				mm_a = sq_q;
				mm_b = sq_q;
			end
		endcase
	end

	mexp_mulmod #(
		.MOD_BITS(MOD_BITS)
	) u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go_q),
		.a      (mm_a),
		.b      (mm_b),
		.m      (mod_q),
		.product(mm_p),
		.done   (mm_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mod_q   <= MOD_BITS'(mexp_pkg::RESET_MODULUS);
			go_q    <= 1'b0;
			cnt_q   <= '0;
		end else begin
			go_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				mod_q <= cfg_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (mod_q == '0) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_RED;
							go_q    <= 1'b1;
						end
					end
				end
				ST_RED: begin
					if (mm_done) begin
						cnt_q   <= '0;
						go_q    <= 1'b1;
						state_q <= exp_q[0] ? ST_ACC : ST_SQ;
					end
				end
				ST_ACC: begin
					if (mm_done) begin
						go_q    <= 1'b1;
						state_q <= ST_SQ;
					end
				end
				ST_SQ: begin
					if (mm_done) begin
						if (cnt_q == EW'(EXP_BITS - 1)) begin
							state_q <= ST_DONE;
						end else begin
							cnt_q   <= cnt_q + 1'b1;
							go_q    <= 1'b1;
							state_q <= (EXP_BITS > 1 && exp_q[EXP_BITS > 1 ? 1 : 0])
								? ST_ACC : ST_SQ;
						end
					end
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			base_q <= base_value;
			exp_q  <= new_exp;
			acc_q  <= (mod_q == '0) ? '0 : one_mod;
		end else if (mm_done) begin
			if (state_q == ST_RED) begin
				sq_q <= mm_p;
			end else if (state_q == ST_ACC) begin
				acc_q <= mm_p;
			end else if (state_q == ST_SQ) begin
				sq_q  <= mm_p;
				exp_q <= exp_q >> 1;
			end
		end
	end

	assign result_valid = (state_q == ST_DONE);
	assign result       = acc_q;

`ifndef SYNTHESIS
	a_result_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (mod_q != '0) |-> (result < mod_q))
		else $error("result not reduced below modulus");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("command taken but block not busy");

	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe longer than one cycle");

	a_done_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		mm_done |-> (state_q == ST_RED || state_q == ST_ACC || state_q == ST_SQ))
		else $error("multiplier finished outside a working state");
`endif

endmodule
